### rtl/pal_pkg.sv
// Package for the positional array list unit: field widths, opcode and
// status codes, and the result record passed from sequencer to output stage.
// No dependencies.
package pal_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int OP_W   = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CNT_OUT_W = 9;

    // opcode(3) + position(9) + value(32) = 44 bits, padded to 48
    localparam int IN_TDATA_W  = 48;
    // status(2) + read_value(32) + count(9) + last_value(32) = 75 bits, padded to 80
    localparam int OUT_TDATA_W = 80;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0]     last_value;
        logic [CNT_OUT_W-1:0] count;
        logic [VAL_W-1:0]     read_value;
        logic [ST_W-1:0]      status;
    } result_t;

endpackage

### rtl/pal_store.sv
// Element store: single-port-write, single-port-read synchronous memory
// with registered read data. Uses pal_pkg.
module pal_store #(
    parameter int DEPTH = pal_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [pal_pkg::VAL_W-1:0]     wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [pal_pkg::VAL_W-1:0]     rdata
);
    import pal_pkg::*;

    logic [VAL_W-1:0] store_reg [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pal_ctrl.sv
// Sequencer for the positional array list: decodes an item, checks it
// against the count, moves elements through the store one per cycle and
// fetches the last element. Uses pal_pkg and drives pal_store.
module pal_ctrl #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pal_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              mem_we,
    output logic [$clog2(CAPACITY)-1:0]       mem_waddr,
    output logic [pal_pkg::VAL_W-1:0]         mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(CAPACITY)-1:0]       mem_raddr,
    input  logic [pal_pkg::VAL_W-1:0]         mem_rdata,
    output logic                              res_load,
    input  logic                              res_free,
    output pal_pkg::result_t                  res
);
    import pal_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SHIFT_UP = 3'd1;
    localparam logic [2:0] S_FILL     = 3'd2;
    localparam logic [2:0] S_SHIFT_DN = 3'd3;
    localparam logic [2:0] S_RDWAIT   = 3'd4;
    localparam logic [2:0] S_LAST     = 3'd5;
    localparam logic [2:0] S_LWAIT    = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;
    logic [VAL_W-1:0]  last_reg, last_next;

    logic [OP_W-1:0]   op_in;
    logic [POS_W-1:0]  pos_in;
    logic [VAL_W-1:0]  val_in;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic [CMP_W-1:0]  cap_c;
    logic [ADDR_W-1:0] pos_a;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] cnt_a;
    logic [ADDR_W-1:0] cnt_m1_a;

    assign op_in    = s_tdata[OP_W-1:0];
    assign pos_in   = s_tdata[OP_W+POS_W-1:OP_W];
    assign val_in   = s_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
    assign pos_c    = CMP_W'(pos_in);
    assign cnt_c    = CMP_W'(count_reg);
    assign cap_c    = CMP_W'(CAPACITY);
    assign pos_a    = pos_c[ADDR_W-1:0];
    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_a    = count_reg[ADDR_W-1:0];
    assign cnt_m1_a = cnt_m1[ADDR_W-1:0];

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        res_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_next    = pos_a;
                    val_next    = val_in;
                    status_next = ST_OK;
                    rd_next     = '0;
                    state_next  = S_LAST;
                    case (op_in)
                        OP_PUSH:
                        begin
                            if (cnt_c >= cap_c)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = cnt_a;
                                mem_wdata  = val_in;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (cnt_c >= cap_c)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                if (pos_c == cnt_c)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_a;
                                    mem_wdata = val_in;
                                end
                                else
                                begin
                                    // move elements up, starting from the top
                                    mem_re     = 1'b1;
                                    mem_raddr  = cnt_m1_a;
                                    idx_next   = cnt_m1_a;
                                    state_next = S_SHIFT_UP;
                                end
                            end
                        end
                        OP_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_c >= cnt_c)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                if (pos_c != CMP_W'(cnt_m1))
                                begin
                                    // move elements down, starting just above the hole
                                    mem_re     = 1'b1;
                                    mem_raddr  = pos_a + 1'b1;
                                    idx_next   = pos_a + 1'b1;
                                    state_next = S_SHIFT_DN;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_a;
                                state_next = S_RDWAIT;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_a;
                                mem_wdata = val_in;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 1'b1;
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - 1'b1;
                    idx_next  = idx_reg - 1'b1;
                end
            end
            S_FILL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                state_next = S_LAST;
            end
            S_SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - 1'b1;
                mem_wdata = mem_rdata;
                // count already holds the old top index
                if (CNT_W'(idx_reg) == count_reg)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_RDWAIT:
            begin
                rd_next    = mem_rdata;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                if (count_reg == '0)
                begin
                    last_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cnt_m1_a;
                    state_next = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                last_next  = mem_rdata;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        last_reg   <= last_next;
    end

    assign res.status     = status_reg;
    assign res.read_value = rd_reg;
    assign res.count      = cnt_c[CNT_OUT_W-1:0];
    assign res.last_value = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_c <= cap_c)
        else $error("element count beyond capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("sequencer did not start on accepted item");

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write to the same entry in one cycle");

    a_dn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_DN |-> CNT_W'(idx_reg) <= count_reg)
        else $error("down shift past the top element");

endmodule

### rtl/pal_out.sv
// Output register for the positional array list: holds one result item
// until the downstream side takes it. Uses pal_pkg.
module pal_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_load,
    input  pal_pkg::result_t                  res,
    output logic                              res_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pal_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pal_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - $bits(result_t);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign res_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, data_reg};

endmodule

### rtl/positional_array_list_unit.sv
// Positional array list unit: a bounded ordered list of 32-bit signed elements
// with push, pop, insert, erase, read and write by index. One result item per
// input item. An accepted item goes from idle through the shift states for an
// insert or erase below the top, then the fill state for an insert, or through
// the read wait for a read; then the last element is fetched (skipped when the
// list is empty afterwards) and the result is loaded. The store's single read
// and single write port move one element per cycle. One item is worked on at a
// time; a finished result waits in an output register while the next item is
// accepted, and the next result is held until that register is free. Built from
// pal_pkg, pal_store, pal_ctrl, pal_out.
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[2:0], position[11:3], value[43:12], zero pad
    input  logic [pal_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], read_value[33:2], count[42:34], last_value[74:43], zero pad
    output logic [pal_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pal_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  mem_rdata;
    logic              res_load;
    logic              res_free;
    result_t           res;

    pal_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_load  (res_load),
        .res_free  (res_free),
        .res       (res)
    );

    pal_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
